// ----- sv/msq_pkg.sv -----
// Shared types, widths and case tables for the marching squares cell unit.
package msq_pkg;

    localparam int VAL_W = 32;
    localparam int MAG_W = VAL_W + 1;
    localparam int ORG_EXT_W = 16;

    typedef logic [1:0] t_corner;

    typedef struct packed {
        logic    vld;
        logic    last;
        t_corner n0;
        t_corner f0;
        t_corner n1;
        t_corner f1;
    } t_ctl;

    // saddle pairings: near/far corner for both endpoints of both segments
    localparam logic [15:0] SADDLE_POS = {2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd2};
    localparam logic [15:0] SADDLE_NEG = {2'd0, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd3};

    function automatic logic [1:0] seg_count(input logic [3:0] code);
        logic [1:0] n;
        case (code)
            4'd0, 4'd15: n = 2'd0;
            4'd5, 4'd10: n = 2'd2;
            default:     n = 2'd1;
        endcase
        return n;
    endfunction

    // endpoints of the single segment of a non-saddle code
    function automatic logic [7:0] seg_ends(input logic [3:0] code);
        logic [7:0] e;
        case (code)
            4'd1, 4'd14: e = {2'd0, 2'd1, 2'd0, 2'd3};
            4'd2, 4'd13: e = {2'd1, 2'd0, 2'd1, 2'd2};
            4'd3, 4'd12: e = {2'd0, 2'd3, 2'd1, 2'd2};
            4'd4, 4'd11: e = {2'd2, 2'd1, 2'd2, 2'd3};
            4'd6, 4'd9:  e = {2'd0, 2'd1, 2'd3, 2'd2};
            4'd7, 4'd8:  e = {2'd3, 2'd0, 2'd3, 2'd2};
            default:     e = '0;
        endcase
        return e;
    endfunction

    function automatic logic corner_dx(input t_corner c);
        return (c == 2'd1) || (c == 2'd2);
    endfunction

    function automatic logic corner_dy(input t_corner c);
        return c[1];
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic [VAL_W-1:0] v);
        logic [MAG_W-1:0] m;
        if (v[VAL_W-1]) begin
            m = (MAG_W'(1) << VAL_W) - {1'b0, v};
        end else begin
            m = {1'b0, v};
        end
        return m;
    endfunction

endpackage

// ----- sv/marching_squares_cell_unit.sv -----
// Marching squares cell unit: cell serializer, bit-per-stage edge dividers, endpoint output.
// Path: cell register, segment register, divider stages, output register.
// Up to one segment per cycle unless stalled; a saddle cell holds input for two segments.
// The restoring divider, one quotient bit per pipeline stage, sets the depth.
// An output stall freezes every stage. Synchronous active-low reset clears all valid bits.
module marching_squares_cell_unit
    import msq_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [31:0]              i_corner_value_0,
    input  logic signed [31:0]              i_corner_value_1,
    input  logic signed [31:0]              i_corner_value_2,
    input  logic signed [31:0]              i_corner_value_3,
    input  logic [11:0]                     i_origin_x,
    input  logic [11:0]                     i_origin_y,
    input  logic [3:0]                      i_case_code,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [COORD_BITS+FRAC_BITS:0]   o_start_x,
    output logic [COORD_BITS+FRAC_BITS:0]   o_start_y,
    output logic [COORD_BITS+FRAC_BITS:0]   o_end_x,
    output logic [COORD_BITS+FRAC_BITS:0]   o_end_y,
    output logic                            o_last_segment
);

    localparam int W   = COORD_BITS + FRAC_BITS + 1;
    localparam int QW  = FRAC_BITS + 1;
    localparam int DW  = MAG_W + 1;
    localparam int RW  = MAG_W + 2;
    localparam int NST = FRAC_BITS + 1;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    logic en;
    logic take;

    // cell serializer stage
    logic                  r_cell_valid;
    logic                  r_idx;
    logic [VAL_W-1:0]      r_v [0:3];
    logic [COORD_BITS-1:0] r_ox, r_oy;
    logic [3:0]            r_code;

    logic [1:0]            cnt;
    logic                  cell_done;
    logic                  emit;
    logic signed [VAL_W+1:0] sum;
    logic                  pos;
    logic [15:0]           ends;
    logic [7:0]            seg;
    logic [MAG_W-1:0]      mag [0:3];
    logic [15:0]           ext_x, ext_y;

    // segment stage
    logic                  r_s1_valid;
    t_ctl                  r_s1_ctl;
    logic [MAG_W-1:0]      r_s1_mn [0:1];
    logic [MAG_W-1:0]      r_s1_mf [0:1];
    logic [COORD_BITS-1:0] r_s1_ox, r_s1_oy;

    // divider stages
    logic [RW-1:0]         r_rem [0:NST-1][0:1];
    logic [DW-1:0]         r_den [0:NST-1][0:1];
    logic [QW-1:0]         r_q   [0:NST-1][0:1];
    t_ctl                  r_ctl [0:NST-1];
    logic [COORD_BITS-1:0] r_dox [0:NST-1];
    logic [COORD_BITS-1:0] r_doy [0:NST-1];

    logic [RW-1:0]         n_rem [0:NST-1][0:1];
    logic [DW-1:0]         n_den [0:NST-1][0:1];
    logic [QW-1:0]         n_q   [0:NST-1][0:1];
    t_ctl                  n_ctl [0:NST-1];
    logic [COORD_BITS-1:0] n_dox [0:NST-1];
    logic [COORD_BITS-1:0] n_doy [0:NST-1];

    // output stage
    logic                  r_out_valid;
    logic [W-1:0]          r_sx, r_sy, r_ex, r_ey;
    logic                  r_last;
    logic [W-1:0]          n_px [0:1];
    logic [W-1:0]          n_py [0:1];

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !take;

    assign ext_x = ORG_EXT_W'(i_origin_x);
    assign ext_y = ORG_EXT_W'(i_origin_y);

    always_comb begin
        cnt = seg_count(r_code);
        sum = (VAL_W+2)'($signed(r_v[0])) + (VAL_W+2)'($signed(r_v[1]))
            + (VAL_W+2)'($signed(r_v[2])) + (VAL_W+2)'($signed(r_v[3]));
        pos = (sum > 0 && $signed(r_v[0]) > 0) || (sum < 0 && $signed(r_v[0]) < 0);
        if (cnt == 2'd2) begin
            ends = pos ? SADDLE_POS : SADDLE_NEG;
        end else begin
            ends = {seg_ends(r_code), 8'd0};
        end
        seg       = r_idx ? ends[7:0] : ends[15:8];
        cell_done = r_cell_valid && ((cnt != 2'd2) || r_idx);
        emit      = r_cell_valid && (cnt != 2'd0);
        take      = en && (!r_cell_valid || cell_done);
        for (int c = 0; c < 4; c++) begin
            mag[c] = mag_of(r_v[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_valid <= 1'b0;
            r_idx        <= 1'b0;
        end else if (take) begin
            r_cell_valid <= i_valid;
            r_idx        <= 1'b0;
        end else if (en && r_cell_valid) begin
            r_idx <= 1'b1;
        end
        if (take && i_valid) begin
            r_v[0] <= i_corner_value_0;
            r_v[1] <= i_corner_value_1;
            r_v[2] <= i_corner_value_2;
            r_v[3] <= i_corner_value_3;
            r_ox   <= ext_x[COORD_BITS-1:0];
            r_oy   <= ext_y[COORD_BITS-1:0];
            r_code <= i_case_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= emit;
        end
        if (en) begin
            r_s1_ctl.vld  <= emit;
            r_s1_ctl.last <= (cnt != 2'd2) || r_idx;
            r_s1_ctl.n0   <= seg[7:6];
            r_s1_ctl.f0   <= seg[5:4];
            r_s1_ctl.n1   <= seg[3:2];
            r_s1_ctl.f1   <= seg[1:0];
            r_s1_mn[0]    <= mag[seg[7:6]];
            r_s1_mf[0]    <= mag[seg[5:4]];
            r_s1_mn[1]    <= mag[seg[3:2]];
            r_s1_mf[1]    <= mag[seg[1:0]];
            r_s1_ox       <= r_ox;
            r_s1_oy       <= r_oy;
        end
    end

    // one quotient bit per stage
    always_comb begin
        for (int s = 0; s < NST; s++) begin
            for (int l = 0; l < 2; l++) begin
                logic [RW-1:0] rin;
                logic [RW-1:0] t;
                logic [DW-1:0] d;
                logic [QW-1:0] qin;
                logic          ge;
                if (s == 0) begin
                    rin = RW'(r_s1_mn[l]);
                    d   = DW'(r_s1_mn[l]) + DW'(r_s1_mf[l]);
                    qin = '0;
                    t   = rin;
                end else begin
                    rin = r_rem[s-1][l];
                    d   = r_den[s-1][l];
                    qin = r_q[s-1][l];
                    t   = rin << 1;
                end
                ge = t >= RW'(d);
                n_rem[s][l] = ge ? (t - RW'(d)) : t;
                n_den[s][l] = d;
                n_q[s][l]   = {qin[QW-2:0], ge};
            end
            if (s == 0) begin
                n_ctl[s] = r_s1_ctl;
                n_dox[s] = r_s1_ox;
                n_doy[s] = r_s1_oy;
            end else begin
                n_ctl[s] = r_ctl[s-1];
                n_dox[s] = r_dox[s-1];
                n_doy[s] = r_doy[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NST; s++) begin
            if (!i_rst_n) begin
                r_ctl[s].vld <= 1'b0;
            end else if (en) begin
                r_ctl[s].vld <= (s == 0) ? r_s1_valid : n_ctl[s].vld;
            end
            if (en) begin
                r_ctl[s].last <= n_ctl[s].last;
                r_ctl[s].n0   <= n_ctl[s].n0;
                r_ctl[s].f0   <= n_ctl[s].f0;
                r_ctl[s].n1   <= n_ctl[s].n1;
                r_ctl[s].f1   <= n_ctl[s].f1;
                r_dox[s]      <= n_dox[s];
                r_doy[s]      <= n_doy[s];
                for (int l = 0; l < 2; l++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_den[s][l] <= n_den[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
        end
    end

    // endpoint placement along the cell edge
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            t_corner      ci;
            t_corner      cj;
            logic [QW-1:0] q;
            logic [W-1:0] f;
            logic [W-1:0] bx;
            logic [W-1:0] by;
            ci = (l == 0) ? r_ctl[NST-1].n0 : r_ctl[NST-1].n1;
            cj = (l == 0) ? r_ctl[NST-1].f0 : r_ctl[NST-1].f1;
            q  = (r_q[NST-1][l] > ONE_Q) ? ONE_Q : r_q[NST-1][l];
            f  = W'(q);
            bx = (W'(r_dox[NST-1]) + W'(corner_dx(ci))) << FRAC_BITS;
            by = (W'(r_doy[NST-1]) + W'(corner_dy(ci))) << FRAC_BITS;
            if (corner_dx(cj) && !corner_dx(ci)) begin
                bx = bx + f;
            end else if (!corner_dx(cj) && corner_dx(ci)) begin
                bx = bx - f;
            end
            if (corner_dy(cj) && !corner_dy(ci)) begin
                by = by + f;
            end else if (!corner_dy(cj) && corner_dy(ci)) begin
                by = by - f;
            end
            n_px[l] = bx;
            n_py[l] = by;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_ctl[NST-1].vld;
        end
        if (en) begin
            r_sx   <= n_px[0];
            r_sy   <= n_py[0];
            r_ex   <= n_px[1];
            r_ey   <= n_py[1];
            r_last <= r_ctl[NST-1].last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_start_x      = r_sx;
    assign o_start_y      = r_sy;
    assign o_end_x        = r_ex;
    assign o_end_y        = r_ey;
    assign o_last_segment = r_last;

endmodule
